@@ hdl/light_timed_door_controller_assert.svh @@
// ----------------------------------------------------------------------------
// Door controller assertion macros
// Immediate-implication and next-cycle checks, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef LIGHT_TIMED_DOOR_CONTROLLER_ASSERT_SVH
`define LIGHT_TIMED_DOOR_CONTROLLER_ASSERT_SVH

`ifndef ASSERT_OFF

`define LDC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("door controller check failed");

`define LDC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("door controller check failed");

`else

`define LDC_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define LDC_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hdl/ldc_pkg.sv @@
// ----------------------------------------------------------------------------
// Door controller package
// Field widths, codes, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package ldc_pkg;

  localparam int ADC_W      = 10;
  localparam int WAIT_W     = 12;
  localparam int POS_W      = 16;
  localparam int CNT8_W     = 8;
  localparam int DAYCNT_W   = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int SEL_DIV     = 340;
  localparam int NUDGE_STEPS = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAY_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SAFE_WAIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_JAM_LIMIT  = 3'd6;

  localparam logic [1:0] SEL_OPEN  = 2'd0;
  localparam logic [1:0] SEL_AUTO  = 2'd1;
  localparam logic [1:0] SEL_CLOSE = 2'd2;
  localparam logic [1:0] SEL_NONE  = 2'd3;

  localparam logic [2:0] MODE_STOP = 3'd0;
  localparam logic [2:0] MODE_SAFE = 3'd1;
  localparam logic [2:0] MODE_AUTO = 3'd2;
  localparam logic [2:0] MODE_JAM  = 3'd3;

  localparam logic [1:0] DRIVE_STOP  = 2'd0;
  localparam logic [1:0] DRIVE_CLOSE = 2'd1;
  localparam logic [1:0] DRIVE_OPEN  = 2'd2;

  localparam logic [1:0] LED_OPEN   = 2'd0;
  localparam logic [1:0] LED_CLOSED = 2'd1;
  localparam logic [1:0] LED_FAULT  = 2'd2;

  localparam logic [1:0] FORCE_NONE = 2'd0;
  localparam logic [1:0] FORCE_ON   = 2'd1;
  localparam logic [1:0] FORCE_OFF  = 2'd2;

  typedef struct packed {
    logic [ADC_W-1:0]  night_threshold;
    logic [ADC_W-1:0]  day_threshold;
    logic [WAIT_W-1:0] change_wait;
    logic [POS_W-1:0]  open_step;
    logic [POS_W-1:0]  closed_step;
    logic [CNT8_W-1:0] safety_wait;
    logic [CNT8_W-1:0] jam_retry_limit;
  } cfg_t;

  typedef struct packed {
    logic             timer_phase;
    logic [ADC_W-1:0] light_sample;
    logic [ADC_W-1:0] selector_sample;
    logic [ADC_W-1:0] delay_sample;
    logic             open_switch;
    logic             closed_switch;
    logic             beam_clear;
    logic             encoder_pulse;
  } pass_in_t;

  typedef struct packed {
    logic [1:0]       motor_drive;
    logic             beam_enable;
    logic             encoder_enable;
    logic [2:0]       run_mode;
    logic             daytime;
    logic [1:0]       led_pattern;
    logic [1:0]       led_forced;
    logic [POS_W-1:0] door_step;
  } pass_out_t;

  // three-position switch reading to position code
  function automatic logic [1:0] selector_pos_of(input logic [ADC_W-1:0] s);
    logic [1:0] p;
    if (s < ADC_W'(SEL_DIV)) begin
      p = SEL_OPEN;
    end else if (s < ADC_W'(2 * SEL_DIV)) begin
      p = SEL_AUTO;
    end else if (s < ADC_W'(3 * SEL_DIV)) begin
      p = SEL_CLOSE;
    end else begin
      p = SEL_NONE;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ldc_if.sv @@
// ----------------------------------------------------------------------------
// Door controller channels
// Valid/ready channels for control-loop passes and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ldc_in_if;
  logic                     valid;
  logic                     ready;
  logic                     timer_phase;
  logic [ldc_pkg::ADC_W-1:0] light_sample;
  logic [ldc_pkg::ADC_W-1:0] selector_sample;
  logic [ldc_pkg::ADC_W-1:0] delay_sample;
  logic                     open_switch;
  logic                     closed_switch;
  logic                     beam_clear;
  logic                     encoder_pulse;

  modport source (
    output valid, timer_phase, light_sample, selector_sample, delay_sample,
           open_switch, closed_switch, beam_clear, encoder_pulse,
    input  ready
  );
  modport sink (
    input  valid, timer_phase, light_sample, selector_sample, delay_sample,
           open_switch, closed_switch, beam_clear, encoder_pulse,
    output ready
  );
endinterface

interface ldc_out_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               motor_drive;
  logic                     beam_enable;
  logic                     encoder_enable;
  logic [2:0]               run_mode;
  logic                     daytime;
  logic [1:0]               led_pattern;
  logic [1:0]               led_forced;
  logic [ldc_pkg::POS_W-1:0] door_step;

  modport source (
    output valid, motor_drive, beam_enable, encoder_enable, run_mode, daytime,
           led_pattern, led_forced, door_step,
    input  ready
  );
  modport sink (
    input  valid, motor_drive, beam_enable, encoder_enable, run_mode, daytime,
           led_pattern, led_forced, door_step,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/light_timed_door_controller.sv @@
// ----------------------------------------------------------------------------
// Light-timed door controller
// Channel    | dir | payload
// pass_in    | in  | timer phase, light/selector/delay samples, switches,
//            |     | beam, encoder pulse
// pass_out   | out | motor drive, enables, run mode, daytime, LEDs, step
// cfg_write  | in  | register write: cfg_index, cfg_data
//
// One transfer per clock on both channels while the result is not stalled;
// a pass is held in the input register and its result in the result register.
// The pass logic lies between the two registers.
// Reset is synchronous and active high; no clearing pass follows it.
// A stalled result holds in its register while the next pass waits in the
// input register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "light_timed_door_controller_assert.svh"

module light_timed_door_controller #(
  parameter int STEP_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [ldc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ldc_pkg::CFG_DATA_W-1:0] cfg_data,
  ldc_in_if.sink                              pass_in,
  ldc_out_if.source                           pass_out
);

  ldc_pkg::cfg_t      cfg;
  ldc_pkg::pass_in_t  in_q;
  ldc_pkg::pass_out_t out_q;
  ldc_pkg::pass_out_t result;
  logic               in_v, out_v, fire;

  assign fire          = in_v && (!out_v || pass_out.ready);
  assign pass_in.ready = !in_v || fire;

  ldc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ldc_pass #(
    .STEP_WIDTH (STEP_WIDTH)
  ) u_pass (
    .clk    (clk),
    .rst    (rst),
    .load   (fire),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (pass_in.ready) begin
      in_v <= pass_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pass_in.valid && pass_in.ready) begin
      in_q.timer_phase     <= pass_in.timer_phase;
      in_q.light_sample    <= pass_in.light_sample;
      in_q.selector_sample <= pass_in.selector_sample;
      in_q.delay_sample    <= pass_in.delay_sample;
      in_q.open_switch     <= pass_in.open_switch;
      in_q.closed_switch   <= pass_in.closed_switch;
      in_q.beam_clear      <= pass_in.beam_clear;
      in_q.encoder_pulse   <= pass_in.encoder_pulse;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (fire) begin
      out_v <= 1'b1;
    end else if (pass_out.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign pass_out.valid          = out_v;
  assign pass_out.motor_drive    = out_q.motor_drive;
  assign pass_out.beam_enable    = out_q.beam_enable;
  assign pass_out.encoder_enable = out_q.encoder_enable;
  assign pass_out.run_mode       = out_q.run_mode;
  assign pass_out.daytime        = out_q.daytime;
  assign pass_out.led_pattern    = out_q.led_pattern;
  assign pass_out.led_forced     = out_q.led_forced;
  assign pass_out.door_step      = out_q.door_step;

  `LDC_ASSERT_NXT(a_in_hold, clk, rst, in_v && !fire, in_v && $stable(in_q))
  `LDC_ASSERT_NXT(a_fire_out, clk, rst, fire, out_v)
  `LDC_ASSERT_NXT(a_open_led, clk, rst, fire && in_q.open_switch, out_q.led_pattern == ldc_pkg::LED_OPEN)
  `LDC_ASSERT_IMP(a_run_enc, clk, rst, out_v && out_q.motor_drive != ldc_pkg::DRIVE_STOP, out_q.encoder_enable)

endmodule

`default_nettype wire

@@ hdl/ldc_cfg.sv @@
// ----------------------------------------------------------------------------
// Door controller configuration registers
// Write-only register file addressed by register index.
// ----------------------------------------------------------------------------
`default_nettype none

module ldc_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [ldc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ldc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ldc_pkg::cfg_t                           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.night_threshold <= 10'd100;
      cfg.day_threshold   <= 10'd200;
      cfg.change_wait     <= 12'd300;
      cfg.open_step       <= 16'd0;
      cfg.closed_step     <= 16'd400;
      cfg.safety_wait     <= 8'd10;
      cfg.jam_retry_limit <= 8'd3;
    end else if (cfg_write) begin
      case (cfg_index)
        ldc_pkg::CFG_NIGHT_THR:  cfg.night_threshold <= cfg_data[ldc_pkg::ADC_W-1:0];
        ldc_pkg::CFG_DAY_THR:    cfg.day_threshold   <= cfg_data[ldc_pkg::ADC_W-1:0];
        ldc_pkg::CFG_CHANGE:     cfg.change_wait     <= cfg_data[ldc_pkg::WAIT_W-1:0];
        ldc_pkg::CFG_OPEN_STEP:  cfg.open_step       <= cfg_data[ldc_pkg::POS_W-1:0];
        ldc_pkg::CFG_CLOSE_STEP: cfg.closed_step     <= cfg_data[ldc_pkg::POS_W-1:0];
        ldc_pkg::CFG_SAFE_WAIT:  cfg.safety_wait     <= cfg_data[ldc_pkg::CNT8_W-1:0];
        ldc_pkg::CFG_JAM_LIMIT:  cfg.jam_retry_limit <= cfg_data[ldc_pkg::CNT8_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/ldc_daynight.sv @@
// ----------------------------------------------------------------------------
// Door controller day/night detection
// Counted hysteresis on the light level, closing delay added toward night.
// ----------------------------------------------------------------------------
`default_nettype none

module ldc_daynight (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        load,
  input  wire logic                        tick,
  input  wire logic [ldc_pkg::ADC_W-1:0]   light,
  input  wire logic [ldc_pkg::ADC_W-1:0]   delay,
  input  wire ldc_pkg::cfg_t               cfg,
  output logic                             is_day_next
);

  localparam int CW = ldc_pkg::DAYCNT_W;

  logic [CW-1:0] night_count;
  logic [CW-1:0] day_count;
  logic          is_day;
  logic [CW-1:0] night_count_next;
  logic [CW-1:0] day_count_next;
  logic [CW-1:0] lim;
  logic [CW:0]   n;

  always_comb begin
    night_count_next = night_count;
    day_count_next   = day_count;
    is_day_next      = is_day;
    lim = CW'(cfg.change_wait) + CW'({delay, 2'b00});
    n   = '0;
    if (tick) begin
      if (light <= cfg.night_threshold) begin
        n = {1'b0, night_count} + 1'b1;
        day_count_next = '0;
        if (n > {1'b0, lim}) begin
          is_day_next = 1'b0;
          n = {1'b0, lim} + 1'b1;
        end
        night_count_next = n[CW-1:0];
      end else if (light >= cfg.day_threshold) begin
        n = {1'b0, day_count} + 1'b1;
        night_count_next = '0;
        if (n > (CW+1)'(cfg.change_wait)) begin
          is_day_next = 1'b1;
          n = (CW+1)'(cfg.change_wait) + 1'b1;
        end
        day_count_next = n[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      night_count <= '0;
      day_count   <= '0;
      is_day      <= 1'b0;
    end else if (load) begin
      night_count <= night_count_next;
      day_count   <= day_count_next;
      is_day      <= is_day_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ldc_pass.sv @@
// ----------------------------------------------------------------------------
// Door controller control pass
// Encoder count, second-tick work, limit switches and selector/mode logic.
// ----------------------------------------------------------------------------
`default_nettype none

module ldc_pass #(
  parameter int STEP_WIDTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire ldc_pkg::pass_in_t item,
  input  wire ldc_pkg::cfg_t cfg,
  output ldc_pkg::pass_out_t result
);

  localparam int CW = (STEP_WIDTH > ldc_pkg::POS_W) ? STEP_WIDTH : ldc_pkg::POS_W;
  localparam logic [STEP_WIDTH-1:0] STEP_MAX = '1;

  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_OPEN  = 2'd1;
  localparam logic [1:0] REQ_CLOSE = 2'd2;
  localparam logic [1:0] REQ_STOP  = 2'd3;

  function automatic logic [STEP_WIDTH-1:0] pos_of(input logic [ldc_pkg::POS_W-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    if (w > CW'(STEP_MAX)) begin
      return STEP_MAX;
    end
    return STEP_WIDTH'(w);
  endfunction

  logic [STEP_WIDTH-1:0] step_count, prev_step_count;
  logic                  motor_dir_close, motor_running, jammed, jam_dir_close;
  logic [7:0]            jam_count, safety_count;
  logic [2:0]            mode;
  logic [1:0]            led_sel, selector_pos;
  logic                  second_pending, beam_en, enc_en;

  logic [STEP_WIDTH-1:0] step_count_next, prev_step_count_next;
  logic                  motor_dir_close_next, motor_running_next;
  logic                  jammed_next, jam_dir_close_next;
  logic [7:0]            jam_count_next, safety_count_next;
  logic [2:0]            mode_next;
  logic [1:0]            led_sel_next, selector_pos_next;
  logic                  second_pending_next, beam_en_next, enc_en_next;

  logic                  tick, is_day_next;
  logic [STEP_WIDTH-1:0] o_pos, c_pos, step_count_pre;
  logic [STEP_WIDTH:0]   up_sum;
  logic [7:0]            wait_done;
  logic [1:0]            req, led_force;

  assign tick      = item.timer_phase && second_pending;
  assign o_pos     = pos_of(cfg.open_step);
  assign c_pos     = pos_of(cfg.closed_step);
  assign wait_done = (cfg.safety_wait == 8'hFF) ? 8'hFF : cfg.safety_wait + 1'b1;

  ldc_daynight u_daynight (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .tick        (tick),
    .light       (item.light_sample),
    .delay       (item.delay_sample),
    .cfg         (cfg),
    .is_day_next (is_day_next)
  );

  always_comb begin
    step_count_next      = step_count;
    prev_step_count_next = prev_step_count;
    motor_dir_close_next = motor_dir_close;
    motor_running_next   = motor_running;
    jammed_next          = jammed;
    jam_dir_close_next   = jam_dir_close;
    jam_count_next       = jam_count;
    safety_count_next    = safety_count;
    mode_next            = mode;
    led_sel_next         = led_sel;
    selector_pos_next    = selector_pos;
    second_pending_next  = !item.timer_phase;
    beam_en_next         = beam_en;
    enc_en_next          = enc_en;
    led_force            = ldc_pkg::FORCE_NONE;
    req                  = REQ_NONE;
    up_sum               = '0;

    // encoder step
    if (motor_running && item.encoder_pulse) begin
      if (motor_dir_close) begin
        if (step_count != STEP_MAX) step_count_next = step_count + 1'b1;
      end else if (step_count != '0) begin
        step_count_next = step_count - 1'b1;
      end
    end

    // one-second work
    if (tick) begin
      if (safety_count != 8'hFF) safety_count_next = safety_count + 1'b1;
      selector_pos_next = ldc_pkg::selector_pos_of(item.selector_sample);
      if (motor_running) begin
        if (step_count_next == prev_step_count) begin
          jammed_next        = 1'b1;
          jam_dir_close_next = motor_dir_close;
          led_sel_next       = ldc_pkg::LED_FAULT;
          if (jam_count != 8'hFF) jam_count_next = jam_count + 1'b1;
        end else begin
          jammed_next = 1'b0;
        end
      end
      prev_step_count_next = step_count_next;
    end

    // limit switches and travel range
    if (item.open_switch) begin
      step_count_next = o_pos;
      led_sel_next    = ldc_pkg::LED_OPEN;
      jammed_next     = 1'b0;
      jam_count_next  = '0;
    end else if (item.closed_switch) begin
      step_count_next = c_pos;
      led_sel_next    = ldc_pkg::LED_CLOSED;
      jammed_next     = 1'b0;
      jam_count_next  = '0;
    end
    if (step_count_next < o_pos) begin
      step_count_next = o_pos;
    end else if (step_count_next > c_pos) begin
      step_count_next = c_pos;
    end

    case (selector_pos_next)
      ldc_pkg::SEL_OPEN:  req = REQ_OPEN;
      ldc_pkg::SEL_CLOSE: req = REQ_CLOSE;
      ldc_pkg::SEL_AUTO: begin
        if (!item.beam_clear) begin
          mode_next         = ldc_pkg::MODE_SAFE;
          led_force         = ldc_pkg::FORCE_ON;
          safety_count_next = '0;
        end else if (jammed_next) begin
          mode_next = (jam_count_next < cfg.jam_retry_limit) ?
                      ldc_pkg::MODE_JAM : ldc_pkg::MODE_STOP;
        end else begin
          if (safety_count_next > cfg.safety_wait || safety_count_next == 8'hFF) begin
            safety_count_next = wait_done;
            mode_next         = ldc_pkg::MODE_AUTO;
          end
          led_force = ldc_pkg::FORCE_OFF;
        end
        case (mode_next)
          ldc_pkg::MODE_STOP: req = REQ_STOP;
          ldc_pkg::MODE_SAFE: begin
            if (!item.closed_switch) req = REQ_OPEN;
            else safety_count_next = wait_done;
          end
          ldc_pkg::MODE_AUTO: begin
            req = is_day_next ? REQ_OPEN : REQ_CLOSE;
            if (item.timer_phase) begin
              // nudge off a limit position that has no switch pressed
              up_sum = {1'b0, step_count_next} + (STEP_WIDTH+1)'(ldc_pkg::NUDGE_STEPS);
              if (step_count_next == o_pos && !item.open_switch) begin
                step_count_next = up_sum[STEP_WIDTH] ? STEP_MAX : up_sum[STEP_WIDTH-1:0];
              end else if (step_count_next == c_pos && !item.closed_switch) begin
                step_count_next = (c_pos < STEP_WIDTH'(ldc_pkg::NUDGE_STEPS)) ? '0 :
                                  c_pos - STEP_WIDTH'(ldc_pkg::NUDGE_STEPS);
              end
            end
          end
          ldc_pkg::MODE_JAM: req = jam_dir_close_next ? REQ_OPEN : REQ_CLOSE;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // motor drive, evaluated on the position before any nudge
  logic drv_run, drv_dir, drv_beam, drv_enc;
  always_comb begin
    drv_run  = motor_running_next;
    drv_dir  = motor_dir_close_next;
    drv_beam = beam_en_next;
    drv_enc  = enc_en_next;
    case (req)
      REQ_OPEN: begin
        if (step_count_pre > o_pos) begin
          drv_enc = 1'b1; drv_run = 1'b1; drv_dir = 1'b0;
        end else begin
          drv_run = 1'b0; drv_enc = 1'b0;
        end
      end
      REQ_CLOSE: begin
        if (step_count_pre < c_pos) begin
          drv_beam = 1'b1; drv_enc = 1'b1; drv_run = 1'b1; drv_dir = 1'b1;
        end else begin
          drv_run = 1'b0; drv_beam = 1'b0; drv_enc = 1'b0;
        end
      end
      REQ_STOP: begin
        drv_run = 1'b0; drv_beam = 1'b0; drv_enc = 1'b0;
      end
      default: ;
    endcase
  end

  // clamped position ahead of the nudge
  always_comb begin
    step_count_pre = step_count;
    if (motor_running && item.encoder_pulse) begin
      if (motor_dir_close) begin
        if (step_count != STEP_MAX) step_count_pre = step_count + 1'b1;
      end else if (step_count != '0) begin
        step_count_pre = step_count - 1'b1;
      end
    end
    if (item.open_switch) begin
      step_count_pre = o_pos;
    end else if (item.closed_switch) begin
      step_count_pre = c_pos;
    end
    if (step_count_pre < o_pos) begin
      step_count_pre = o_pos;
    end else if (step_count_pre > c_pos) begin
      step_count_pre = c_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count      <= '0;
      prev_step_count <= '0;
      motor_dir_close <= 1'b0;
      motor_running   <= 1'b0;
      jammed          <= 1'b0;
      jam_dir_close   <= 1'b0;
      jam_count       <= '0;
      safety_count    <= '0;
      mode            <= ldc_pkg::MODE_STOP;
      led_sel         <= ldc_pkg::LED_OPEN;
      selector_pos    <= ldc_pkg::SEL_OPEN;
      second_pending  <= 1'b0;
      beam_en         <= 1'b0;
      enc_en          <= 1'b0;
    end else if (load) begin
      step_count      <= step_count_next;
      prev_step_count <= prev_step_count_next;
      motor_dir_close <= drv_dir;
      motor_running   <= drv_run;
      jammed          <= jammed_next;
      jam_dir_close   <= jam_dir_close_next;
      jam_count       <= jam_count_next;
      safety_count    <= safety_count_next;
      mode            <= mode_next;
      led_sel         <= led_sel_next;
      selector_pos    <= selector_pos_next;
      second_pending  <= second_pending_next;
      beam_en         <= drv_beam;
      enc_en          <= drv_enc;
    end
  end

  always_comb begin
    result.motor_drive    = !drv_run ? ldc_pkg::DRIVE_STOP :
                            (drv_dir ? ldc_pkg::DRIVE_CLOSE : ldc_pkg::DRIVE_OPEN);
    result.beam_enable    = drv_beam;
    result.encoder_enable = drv_enc;
    result.run_mode       = mode_next;
    result.daytime        = is_day_next;
    result.led_pattern    = led_sel_next;
    result.led_forced     = led_force;
    result.door_step      = ldc_pkg::POS_W'(step_count_next);
  end

endmodule

`default_nettype wire

@@ tb/light_timed_door_controller_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Light-timed door controller testbench
// Drives control-loop passes through a queue-fed driver, predicts every
// status transfer with a local model of the door logic, and compares each
// returned status field by field. Several register settings are loaded
// between phases, the extremes among them; both channels idle in random
// bursts except in the final phase.
// ----------------------------------------------------------------------------

module light_timed_door_controller_test;
  import ldc_pkg::*;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int STALL_LIMIT     = 1000;
  localparam int DELAY_SCALE     = 4;
  localparam logic [POS_W-1:0]  POS_MAX = '1;
  localparam logic [CNT8_W-1:0] CNT_MAX = '1;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ldc_in_if  pass_in_ch ();
  ldc_out_if pass_out_ch ();

  light_timed_door_controller DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pass_in   (pass_in_ch),
    .pass_out  (pass_out_ch)
  );

  always #1 clk = ~clk;

  // door model state
  cfg_t door_cfg;
  logic [DAYCNT_W-1:0] night_cnt, day_cnt;
  logic is_day, motor_on, motor_close, jam, jam_close, tick_armed, beam_on, enc_on;
  logic [POS_W-1:0] door_pos, tick_pos;
  logic [CNT8_W-1:0] jam_cnt, safe_cnt;
  logic [2:0] run_state;
  logic [1:0] led_sel, lamp_force, sel_pos;
  logic [ADC_W-1:0] light_lvl;
  logic [WAIT_W-1:0] close_dly;

  pass_in_t  door_pass_q[$];
  pass_out_t door_status_q[$];
  pass_in_t  on_wire;
  pass_out_t want;
  int passes_sent, passes_taken, failures;
  int in_gap, out_stall, quiet_cycles;
  bit calm;

  function automatic logic [CNT8_W-1:0] safety_done();
    return (door_cfg.safety_wait == CNT_MAX) ? CNT_MAX : door_cfg.safety_wait + 1'b1;
  endfunction

  task automatic open_motor();
    if (door_pos > door_cfg.open_step) begin
      enc_on = 1'b1; motor_on = 1'b1; motor_close = 1'b0;
    end else begin
      motor_on = 1'b0; enc_on = 1'b0;
    end
  endtask

  task automatic close_motor();
    if (door_pos < door_cfg.closed_step) begin
      beam_on = 1'b1; enc_on = 1'b1; motor_on = 1'b1; motor_close = 1'b1;
    end else begin
      motor_on = 1'b0; beam_on = 1'b0; enc_on = 1'b0;
    end
  endtask

  task automatic predict_door_pass(input pass_in_t p, output pass_out_t r);
    int n, lim;
    logic [POS_W-1:0] o, c;
    lamp_force = FORCE_NONE;
    if (motor_on && p.encoder_pulse) begin
      if (motor_close) begin
        if (door_pos != POS_MAX) door_pos = door_pos + 1'b1;
      end else if (door_pos != '0) begin
        door_pos = door_pos - 1'b1;
      end
    end
    if (p.timer_phase) begin
      if (tick_armed) begin
        tick_armed = 1'b0;
        if (safe_cnt != CNT_MAX) safe_cnt = safe_cnt + 1'b1;
        light_lvl = p.light_sample;
        sel_pos = 2'(int'(p.selector_sample) / SEL_DIV);
        close_dly = WAIT_W'(int'(p.delay_sample) * DELAY_SCALE);
        // day/night hysteresis, closing delay added on the way to night
        if (light_lvl <= door_cfg.night_threshold) begin
          lim = int'(door_cfg.change_wait) + int'(close_dly);
          n = int'(night_cnt) + 1;
          day_cnt = '0;
          if (n > lim) begin
            is_day = 1'b0;
            n = lim + 1;
          end
          night_cnt = DAYCNT_W'(n);
        end else if (light_lvl >= door_cfg.day_threshold) begin
          n = int'(day_cnt) + 1;
          night_cnt = '0;
          if (n > int'(door_cfg.change_wait)) begin
            is_day = 1'b1;
            n = int'(door_cfg.change_wait) + 1;
          end
          day_cnt = DAYCNT_W'(n);
        end
        if (motor_on) begin
          if (door_pos == tick_pos) begin
            jam = 1'b1;
            jam_close = motor_close;
            led_sel = LED_FAULT;
            if (jam_cnt != CNT_MAX) jam_cnt = jam_cnt + 1'b1;
          end else begin
            jam = 1'b0;
          end
        end
        tick_pos = door_pos;
      end
    end else begin
      tick_armed = 1'b1;
    end

    o = door_cfg.open_step;
    c = door_cfg.closed_step;
    if (p.open_switch) begin
      door_pos = o; led_sel = LED_OPEN; jam = 1'b0; jam_cnt = '0;
    end else if (p.closed_switch) begin
      door_pos = c; led_sel = LED_CLOSED; jam = 1'b0; jam_cnt = '0;
    end
    if (door_pos < o) door_pos = o;
    else if (door_pos > c) door_pos = c;

    case (sel_pos)
      SEL_OPEN: open_motor();
      SEL_AUTO: begin
        if (!p.beam_clear) begin
          run_state = MODE_SAFE; lamp_force = FORCE_ON; safe_cnt = '0;
        end else if (jam) begin
          run_state = (jam_cnt < door_cfg.jam_retry_limit) ? MODE_JAM : MODE_STOP;
        end else begin
          if (safe_cnt > door_cfg.safety_wait || safe_cnt == CNT_MAX) begin
            safe_cnt = safety_done();
            run_state = MODE_AUTO;
          end
          lamp_force = FORCE_OFF;
        end
        case (run_state)
          MODE_STOP: begin
            motor_on = 1'b0; beam_on = 1'b0; enc_on = 1'b0;
          end
          MODE_SAFE: begin
            if (!p.closed_switch) open_motor();
            else safe_cnt = safety_done();
          end
          MODE_AUTO: begin
            if (is_day) open_motor();
            else close_motor();
            // nudge off a limit position between ticks
            if (!tick_armed) begin
              if (door_pos == o && !p.open_switch) begin
                door_pos = (door_pos > POS_MAX - POS_W'(NUDGE_STEPS)) ? POS_MAX :
                           door_pos + POS_W'(NUDGE_STEPS);
              end else if (door_pos == c && !p.closed_switch) begin
                door_pos = (c < POS_W'(NUDGE_STEPS)) ? '0 : c - POS_W'(NUDGE_STEPS);
              end
            end
          end
          MODE_JAM: begin
            if (jam_close) open_motor();
            else close_motor();
          end
          default: ;
        endcase
      end
      SEL_CLOSE: close_motor();
      default: ;
    endcase

    r.motor_drive    = motor_on ? (motor_close ? DRIVE_CLOSE : DRIVE_OPEN) : DRIVE_STOP;
    r.beam_enable    = beam_on;
    r.encoder_enable = enc_on;
    r.run_mode       = run_state;
    r.daytime        = is_day;
    r.led_pattern    = led_sel;
    r.led_forced     = lamp_force;
    r.door_step      = door_pos;
  endtask

  task automatic push_pass(input bit tp, input int light, input int sel, input int dly,
                           input bit osw, input bit csw, input bit beam, input bit pulse);
    pass_in_t p;
    p.timer_phase     = tp;
    p.light_sample    = light[ADC_W-1:0];
    p.selector_sample = sel[ADC_W-1:0];
    p.delay_sample    = dly[ADC_W-1:0];
    p.open_switch     = osw;
    p.closed_switch   = csw;
    p.beam_clear      = beam;
    p.encoder_pulse   = pulse;
    door_pass_q.push_back(p);
    passes_sent++;
  endtask

  task automatic wait_idle();
    while (passes_taken != passes_sent || door_status_q.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    logic [CFG_IDX_W-1:0] idx [7];
    logic [CFG_DATA_W-1:0] val [7];
    idx = '{CFG_NIGHT_THR, CFG_DAY_THR, CFG_CHANGE, CFG_OPEN_STEP, CFG_CLOSE_STEP,
            CFG_SAFE_WAIT, CFG_JAM_LIMIT};
    val = '{CFG_DATA_W'(s.night_threshold), CFG_DATA_W'(s.day_threshold),
            CFG_DATA_W'(s.change_wait), CFG_DATA_W'(s.open_step),
            CFG_DATA_W'(s.closed_step), CFG_DATA_W'(s.safety_wait),
            CFG_DATA_W'(s.jam_retry_limit)};
    for (int k = 0; k < 7; k++) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
    end
    @(posedge clk);
    cfg_write <= 1'b0;
    door_cfg = s;
  endtask

  task automatic check_field(input string what, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
      failures++;
    end
  endtask

  // pass driver
  always @(posedge clk) begin
    if (rst) begin
      pass_in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (pass_in_ch.valid && pass_in_ch.ready) begin
        predict_door_pass(on_wire, want);
        door_status_q.push_back(want);
        passes_taken++;
      end
      if (!pass_in_ch.valid || pass_in_ch.ready) begin
        if (in_gap != 0) begin
          in_gap--;
          pass_in_ch.valid <= 1'b0;
        end else if (door_pass_q.size() != 0) begin
          on_wire = door_pass_q.pop_front();
          pass_in_ch.timer_phase     <= on_wire.timer_phase;
          pass_in_ch.light_sample    <= on_wire.light_sample;
          pass_in_ch.selector_sample <= on_wire.selector_sample;
          pass_in_ch.delay_sample    <= on_wire.delay_sample;
          pass_in_ch.open_switch     <= on_wire.open_switch;
          pass_in_ch.closed_switch   <= on_wire.closed_switch;
          pass_in_ch.beam_clear      <= on_wire.beam_clear;
          pass_in_ch.encoder_pulse   <= on_wire.encoder_pulse;
          pass_in_ch.valid           <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 9);
        end else begin
          pass_in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // status monitor
  always @(posedge clk) begin
    if (rst) begin
      pass_out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (pass_out_ch.valid && pass_out_ch.ready) begin
        if (door_status_q.size() == 0) begin
          $display("%0t: status transfer with nothing expected", $time);
          failures++;
        end else begin
          want = door_status_q.pop_front();
          check_field("motor_drive", want.motor_drive, pass_out_ch.motor_drive);
          check_field("beam_enable", want.beam_enable, pass_out_ch.beam_enable);
          check_field("encoder_enable", want.encoder_enable, pass_out_ch.encoder_enable);
          check_field("run_mode", want.run_mode, pass_out_ch.run_mode);
          check_field("daytime", want.daytime, pass_out_ch.daytime);
          check_field("led_pattern", want.led_pattern, pass_out_ch.led_pattern);
          check_field("led_forced", want.led_forced, pass_out_ch.led_forced);
          check_field("door_step", want.door_step, pass_out_ch.door_step);
        end
      end
      if (out_stall != 0) begin
        out_stall--;
        pass_out_ch.ready <= 1'b0;
      end else begin
        pass_out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 11) == 0) out_stall = $urandom_range(1, 9);
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (pass_in_ch.valid && pass_in_ch.ready) ||
        (pass_out_ch.valid && pass_out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    cfg_t s;
    bit tp;
    int sky, knob, sel, dly;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pass_in_ch.valid = 1'b0;
    pass_in_ch.timer_phase = 1'b0;
    pass_in_ch.light_sample = '0;
    pass_in_ch.selector_sample = '0;
    pass_in_ch.delay_sample = '0;
    pass_in_ch.open_switch = 1'b0;
    pass_in_ch.closed_switch = 1'b0;
    pass_in_ch.beam_clear = 1'b0;
    pass_in_ch.encoder_pulse = 1'b0;
    pass_out_ch.ready = 1'b0;
    calm = 1'b0;
    passes_sent = 0;
    passes_taken = 0;
    failures = 0;

    door_cfg.night_threshold = 100;
    door_cfg.day_threshold = 200;
    door_cfg.change_wait = 300;
    door_cfg.open_step = 0;
    door_cfg.closed_step = 400;
    door_cfg.safety_wait = 10;
    door_cfg.jam_retry_limit = 3;
    night_cnt = '0; day_cnt = '0; is_day = 1'b0; door_pos = '0; tick_pos = '0;
    motor_close = 1'b0; motor_on = 1'b0; jam = 1'b0; jam_close = 1'b0;
    jam_cnt = '0; safe_cnt = '0; run_state = MODE_STOP; led_sel = LED_OPEN;
    tick_armed = 1'b0; light_lvl = '0; sel_pos = SEL_OPEN; close_dly = '0;
    beam_on = 1'b0; enc_on = 1'b0; lamp_force = FORCE_NONE;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, selector boundaries, closing travel, jam,
    // beam break, limit switches and the no-change selector band
    push_pass(0, 0, 0, 0, 0, 0, 1, 0);
    push_pass(1, 0, 339, 0, 0, 0, 1, 0);
    push_pass(0, 1023, 1023, 1023, 1, 1, 1, 1);
    push_pass(1, 1023, 1023, 1023, 0, 0, 0, 1);
    push_pass(0, 512, 680, 0, 0, 0, 1, 1);
    push_pass(1, 512, 680, 0, 0, 0, 1, 0);
    push_pass(0, 512, 680, 0, 0, 0, 1, 1);
    push_pass(1, 512, 680, 0, 0, 0, 1, 1);
    push_pass(0, 512, 680, 0, 0, 0, 1, 0);
    push_pass(1, 512, 680, 0, 0, 0, 1, 0);
    push_pass(0, 512, 340, 0, 0, 0, 0, 0);
    push_pass(1, 512, 340, 0, 0, 0, 0, 0);
    push_pass(0, 512, 679, 0, 0, 0, 0, 1);
    push_pass(1, 512, 679, 0, 0, 1, 0, 0);
    push_pass(0, 100, 679, 0, 0, 0, 1, 0);
    push_pass(1, 100, 679, 0, 0, 0, 1, 0);
    push_pass(0, 100, 1019, 0, 0, 0, 1, 0);
    push_pass(1, 100, 1020, 0, 1, 0, 1, 0);
    push_pass(0, 200, 0, 0, 0, 0, 1, 1);
    push_pass(1, 200, 0, 0, 0, 0, 1, 1);
    push_pass(1, 99, 1019, 1, 0, 0, 1, 1);

    tp = 1'b1;
    sky = 0;
    knob = 4;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        wait_idle();
        case (ph)
          1: s = '0;
          2: s = '1;
          3: begin
            s.night_threshold = 300;
            s.day_threshold = 600;
            s.change_wait = 2;
            s.open_step = POS_MAX;
            s.closed_step = POS_MAX;
            s.safety_wait = 0;
            s.jam_retry_limit = 2;
          end
          4: begin
            s.night_threshold = 400;
            s.day_threshold = 500;
            s.change_wait = 1;
            s.open_step = 0;
            s.closed_step = 3;
            s.safety_wait = 1;
            s.jam_retry_limit = 1;
          end
          default: begin
            s.night_threshold = $urandom_range(0, 700);
            s.day_threshold = s.night_threshold + $urandom_range(0, 323);
            s.change_wait = $urandom_range(0, 6);
            s.open_step = $urandom_range(0, 40);
            s.closed_step = s.open_step + $urandom_range(0, 40);
            s.safety_wait = $urandom_range(0, 4);
            s.jam_retry_limit = $urandom_range(0, 5);
          end
        endcase
        load_settings(s);
      end
      if (ph == PHASES - 1) calm = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 14) == 0) sky = $urandom_range(0, 2);
        if ($urandom_range(0, 19) == 0) knob = $urandom_range(0, 5);
        if ($urandom_range(0, 9) != 0) tp = !tp;
        case (knob)
          0: sel = $urandom_range(0, SEL_DIV - 1);
          1: sel = $urandom_range(2 * SEL_DIV, 3 * SEL_DIV - 1);
          2: sel = $urandom_range(3 * SEL_DIV, 1023);
          3: sel = $urandom_range(0, 1023);
          default: sel = $urandom_range(SEL_DIV, 2 * SEL_DIV - 1);
        endcase
        dly = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 3);
        push_pass(tp,
                  (sky == 0) ? $urandom_range(0, door_cfg.night_threshold) :
                  (sky == 1) ? $urandom_range(door_cfg.day_threshold, 1023) :
                               $urandom_range(0, 1023),
                  sel, dly,
                  $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0,
                  $urandom_range(0, 15) != 0, $urandom_range(0, 2) != 0);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
